// File: rtl/core/xtea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA package
// Beat types, cipher constants and register codes shared by the XTEA core.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned KEY_WORDS       = 4;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned HALF_ROUNDS_DEF = 64;

  localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

  typedef enum logic {
    OP_ENCIPHER = 1'b0,
    OP_DECIPHER = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_WORD_0 = 3'd0,
    CFG_KEY_WORD_1 = 3'd1,
    CFG_KEY_WORD_2 = 3'd2,
    CFG_KEY_WORD_3 = 3'd3
  } cfg_reg_e;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] block_low_in;
    logic [WORD_W-1:0] block_high_in;
  } in_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] block_low_out;
    logic [WORD_W-1:0] block_high_out;
  } out_beat_t;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } stage_t;

endpackage

// File: rtl/core/xtea_round_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA round cell
// One half-round of the cipher with its own stage register and handshake.
// ----------------------------------------------------------------------------
module xtea_round_cell #(
  parameter int unsigned HALF_ROUNDS = xtea_pkg::HALF_ROUNDS_DEF,
  parameter int unsigned INDEX       = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xtea_pkg::key_t   keys_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  xtea_pkg::stage_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output xtea_pkg::stage_t data_o
);

  localparam int unsigned FULL_ROUNDS = (HALF_ROUNDS + 1) / 2;
  localparam bit          PARITY      = (INDEX % 2) == 1;
  localparam int unsigned ENC_STEPS   = (INDEX + 1) / 2;
  localparam int unsigned DEC_STEPS   = FULL_ROUNDS - ENC_STEPS;

  localparam logic [63:0] EncProd = 64'(xtea_pkg::XTEA_DELTA) * 64'(ENC_STEPS);
  localparam logic [63:0] DecProd = 64'(xtea_pkg::XTEA_DELTA) * 64'(DEC_STEPS);
  localparam logic [31:0] EncSum  = EncProd[31:0];
  localparam logic [31:0] DecSum  = DecProd[31:0];
  localparam logic [1:0]  EncKey  = PARITY ? EncSum[12:11] : EncSum[1:0];
  localparam logic [1:0]  DecKey  = PARITY ? DecSum[1:0] : DecSum[12:11];

  logic             valid_q;
  xtea_pkg::stage_t data_q, data_d;
  logic             is_enc, upd_v0;
  logic [31:0]      src, tgt, mix, rsum, rkey, tweak, res;

  always_comb begin
    is_enc = (data_i.op == xtea_pkg::OP_ENCIPHER);
    upd_v0 = is_enc ? !PARITY : PARITY;
    src    = upd_v0 ? data_i.v1 : data_i.v0;
    tgt    = upd_v0 ? data_i.v0 : data_i.v1;
    mix    = ((src << 4) ^ (src >> 5)) + src;
    rsum   = is_enc ? EncSum : DecSum;
    rkey   = is_enc ? keys_i[EncKey] : keys_i[DecKey];
    tweak  = mix ^ (rsum + rkey);
    res    = is_enc ? (tgt + tweak) : (tgt - tweak);
    data_d = data_i;
    if (upd_v0) begin
      data_d.v0 = res;
    end else begin
      data_d.v1 = res;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  a_take_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> valid_q)
    else $error("cell did not capture an accepted beat");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(data_q)))
    else $error("stalled cell lost or changed its beat");

  a_idle_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_o && !valid_i) |=> !valid_q)
    else $error("cell kept a beat after it moved on");

endmodule

// File: rtl/core/xtea_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher
// Enciphers or deciphers 64-bit blocks under a 128-bit key, one beat a cycle while the receiver keeps up.
// ----------------------------------------------------------------------------
// Usage:
//   Load the four key words through the write port (cfg_we_i, cfg_idx_i,
//   cfg_data_i) while no beat is in flight; indexes above three are dropped.
//   Input beats carry the op bit and both block halves on in_beat_i with a
//   valid/ready handshake; results leave on out_beat_o the same way.
//   The core is a chain of HALF_ROUNDS round cells, one half-round each, every
//   cell holding one beat in its stage register. Throughput is one beat per
//   cycle while the receiver takes results, set by the single stage register
//   in each cell.
//   When the receiver stalls, the last cell holds its beat and the stall
//   moves backward only through occupied cells: input beats keep entering
//   until every cell is full. in_ready_o then drops.
//   Reset clears all cell valid bits and the key words to zero; the core
//   accepts beats as soon as reset is released.
// ----------------------------------------------------------------------------
module xtea_block_cipher #(
  parameter int unsigned HALF_ROUNDS = xtea_pkg::HALF_ROUNDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [xtea_pkg::WORD_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  xtea_pkg::in_beat_t            in_beat_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output xtea_pkg::out_beat_t           out_beat_o
);

  xtea_pkg::key_t   key_q;
  logic [HALF_ROUNDS:0] vld;
  logic [HALF_ROUNDS:0] rdy;
  xtea_pkg::stage_t dat [HALF_ROUNDS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      case (xtea_pkg::cfg_reg_e'(cfg_idx_i))
        xtea_pkg::CFG_KEY_WORD_0: key_q[0] <= cfg_data_i;
        xtea_pkg::CFG_KEY_WORD_1: key_q[1] <= cfg_data_i;
        xtea_pkg::CFG_KEY_WORD_2: key_q[2] <= cfg_data_i;
        xtea_pkg::CFG_KEY_WORD_3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vld[0]    = in_valid_i;
  assign in_ready_o = rdy[0];
  assign dat[0]    = '{op: in_beat_i.op, v0: in_beat_i.block_low_in,
                       v1: in_beat_i.block_high_in};

  for (genvar i = 0; i < HALF_ROUNDS; i++) begin : g_cell
    xtea_round_cell #(
      .HALF_ROUNDS(HALF_ROUNDS),
      .INDEX      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .keys_i (key_q),
      .valid_i(vld[i]),
      .ready_o(rdy[i]),
      .data_i (dat[i]),
      .valid_o(vld[i+1]),
      .ready_i(rdy[i+1]),
      .data_o (dat[i+1])
    );
  end

  assign rdy[HALF_ROUNDS]          = out_ready_i;
  assign out_valid_o               = vld[HALF_ROUNDS];
  assign out_beat_o.block_low_out  = dat[HALF_ROUNDS].v0;
  assign out_beat_o.block_high_out = dat[HALF_ROUNDS].v1;

  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld[HALF_ROUNDS:1]) && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while every cell is full and stalled");

  a_drain_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !vld[HALF_ROUNDS-1]) |=> !out_valid_o)
    else $error("output beat repeated after it was taken");

  a_key_ignored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (int'(cfg_idx_i) >= xtea_pkg::KEY_WORDS)) |=> $stable(key_q))
    else $error("key changed on a write to an unused index");

endmodule

// File: tb/sv/xtea_block_cipher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Streams 64-bit blocks through the cipher pipeline under several keys and
// back-pressure profiles. Every result beat is checked against a bit-exact
// model of the XTEA rounds kept here. Round trips are checked against the
// original plaintext. A long receiver stall fills the pipeline.
// ----------------------------------------------------------------------------
module xtea_block_cipher_test;
  import xtea_pkg::*;

  localparam int unsigned LATENCY      = HALF_ROUNDS_DEF;
  localparam int unsigned RANDOM_BEATS = 684;
  localparam int unsigned CHUNKS       = 6;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_PRINTS   = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 3'd7;
  localparam logic [WORD_W-1:0]    ALL_ONES          = '1;

  typedef enum logic [1:0] {
    ROW_BLOCK,
    ROW_TRIP,
    ROW_KEY
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    op_e                   op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [WORD_W-1:0]     word_a;
    logic [WORD_W-1:0]     word_b;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 22;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_BLOCK, OP_ENCIPHER, '0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLOCK, OP_DECIPHER, '0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_BLOCK, OP_ENCIPHER, '0, ALL_ONES,      ALL_ONES},
    '{ROW_BLOCK, OP_DECIPHER, '0, ALL_ONES,      ALL_ONES},
    '{ROW_TRIP,  OP_ENCIPHER, '0, 32'h0123_4567, 32'h89AB_CDEF},
    '{ROW_KEY,   OP_ENCIPHER, CFG_KEY_WORD_0,    ALL_ONES,      '0},
    '{ROW_KEY,   OP_ENCIPHER, CFG_KEY_WORD_1,    ALL_ONES,      '0},
    '{ROW_KEY,   OP_ENCIPHER, CFG_KEY_WORD_2,    ALL_ONES,      '0},
    '{ROW_KEY,   OP_ENCIPHER, CFG_KEY_WORD_3,    ALL_ONES,      '0},
    '{ROW_KEY,   OP_ENCIPHER, CFG_IDX_UNUSED_LO, 32'h0000_0000, '0},
    '{ROW_KEY,   OP_ENCIPHER, CFG_IDX_UNUSED_HI, 32'h1234_5678, '0},
    '{ROW_BLOCK, OP_ENCIPHER, '0, 32'h0000_0000, ALL_ONES},
    '{ROW_BLOCK, OP_DECIPHER, '0, ALL_ONES,      32'h0000_0000},
    '{ROW_TRIP,  OP_ENCIPHER, '0, 32'h0000_0000, 32'h0000_0000},
    '{ROW_TRIP,  OP_ENCIPHER, '0, ALL_ONES,      ALL_ONES},
    '{ROW_KEY,   OP_ENCIPHER, CFG_KEY_WORD_0,    32'h0000_0001, '0},
    '{ROW_KEY,   OP_ENCIPHER, CFG_KEY_WORD_1,    32'h8000_0000, '0},
    '{ROW_KEY,   OP_ENCIPHER, CFG_KEY_WORD_2,    32'hA5A5_A5A5, '0},
    '{ROW_KEY,   OP_ENCIPHER, CFG_KEY_WORD_3,    32'h5A5A_5A5A, '0},
    '{ROW_BLOCK, OP_ENCIPHER, '0, 32'h8000_0000, 32'h0000_0001},
    '{ROW_BLOCK, OP_DECIPHER, '0, 32'h0000_0001, 32'h8000_0000},
    '{ROW_TRIP,  OP_ENCIPHER, '0, 32'hDEAD_BEEF, 32'h0BAD_F00D}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_beat_t             in_beat_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_beat_t            out_beat_o;

  key_t        cipher_key;
  out_beat_t   cipher_expect_q [$];
  int unsigned error_count   = 0;
  int unsigned beats_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned cfg_writes    = 0;
  int unsigned input_stalls  = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_asked    = 0;
  int unsigned hold_taken    = 0;
  int unsigned hold_left     = 0;

  xtea_block_cipher #(
    .HALF_ROUNDS(HALF_ROUNDS_DEF)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [WORD_W-1:0] mix_half(logic [WORD_W-1:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic out_beat_t cipher_block(op_e op, logic [WORD_W-1:0] lo,
                                             logic [WORD_W-1:0] hi);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
    v0 = lo;
    v1 = hi;
    if (op == OP_ENCIPHER) begin
      sum = '0;
      for (int i = 0; i < HALF_ROUNDS_DEF; i++) begin
        if (i % 2 == 0) begin
          v0  = v0 + (mix_half(v1) ^ (sum + cipher_key[sum[1:0]]));
          sum = sum + XTEA_DELTA;
        end else begin
          v1 = v1 + (mix_half(v0) ^ (sum + cipher_key[sum[12:11]]));
        end
      end
    end else begin
      sum = XTEA_DELTA * ((HALF_ROUNDS_DEF + 1) / 2);
      for (int i = 0; i < HALF_ROUNDS_DEF; i++) begin
        if (i % 2 == 0) begin
          v1  = v1 - (mix_half(v0) ^ (sum + cipher_key[sum[12:11]]));
          sum = sum - XTEA_DELTA;
        end else begin
          v0 = v0 - (mix_half(v1) ^ (sum + cipher_key[sum[1:0]]));
        end
      end
    end
    return '{block_low_out: v0, block_high_out: v1};
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return ALL_ONES;
      2: return 32'h1 << $urandom_range(WORD_W - 1);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("mismatch on %s: got %h, want %h (result beat %0d)",
               what, got, want, beats_checked);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    if (idx < KEY_WORDS) begin
      cipher_key[idx[1:0]] = data;
    end
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (cipher_expect_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_beat(op_e op, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                           out_beat_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_beat_i  = '{op: op, block_low_in: lo, block_high_in: hi};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cipher_expect_q.push_back(want);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_predicted(op_e op, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    send_beat(op, lo, hi, cipher_block(op, lo, hi));
  endtask

  // decipher of the predicted ciphertext must give the plaintext back
  task automatic send_round_trip(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
    out_beat_t ct;
    ct = cipher_block(OP_ENCIPHER, lo, hi);
    send_beat(OP_ENCIPHER, lo, hi, ct);
    send_beat(OP_DECIPHER, ct.block_low_out, ct.block_high_out,
              '{block_low_out: lo, block_high_out: hi});
  endtask

  task automatic load_random_key();
    wait_drained();
    write_cfg(CFG_KEY_WORD_0, random_word());
    write_cfg(CFG_KEY_WORD_1, random_word());
    write_cfg(CFG_KEY_WORD_2, random_word());
    write_cfg(CFG_KEY_WORD_3, random_word());
    write_cfg(CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_HI, CFG_IDX_UNUSED_LO)),
              $urandom());
  endtask

  task automatic send_random_blocks(int unsigned count);
    int unsigned n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(3) == 0) begin
        send_round_trip(random_word(), random_word());
        n += 2;
      end else begin
        send_predicted(op_e'($urandom_range(1)), random_word(), random_word());
        n++;
      end
    end
    in_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_taken != hold_asked) begin
      hold_left  = HOLD_CYCLES;
      hold_taken = hold_asked;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk_i) begin : check_results
    out_beat_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_ready_o) begin
        input_stalls++;
      end
      if (out_valid_o && out_ready_i) begin
        if (cipher_expect_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", out_beat_o.block_low_out, '0);
        end else begin
          want = cipher_expect_q.pop_front();
          if (out_beat_o.block_low_out !== want.block_low_out) begin
            report_mismatch("block_low_out", out_beat_o.block_low_out, want.block_low_out);
          end
          if (out_beat_o.block_high_out !== want.block_high_out) begin
            report_mismatch("block_high_out", out_beat_o.block_high_out,
                            want.block_high_out);
          end
        end
        beats_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout at cycle %0d with %0d results pending",
             cycle_count, cipher_expect_q.size());
    $display("xtea_block_cipher_test: done, errors");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_KEY_WORD_0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_beat_i  = '0;
    cipher_key = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 72;
    for (int r = 0; r < DIR_ROWS; r++) begin
      case (dir_rows[r].kind)
        ROW_BLOCK: begin
          send_predicted(dir_rows[r].op, dir_rows[r].word_a, dir_rows[r].word_b);
        end
        ROW_TRIP: begin
          send_round_trip(dir_rows[r].word_a, dir_rows[r].word_b);
        end
        default: begin
          wait_drained();
          write_cfg(dir_rows[r].idx, dir_rows[r].word_a);
        end
      endcase
    end

    for (int c = 0; c < CHUNKS; c++) begin
      case (c / 2)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 72;
        end
        1: begin
          send_idle_pct = 72;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_random_key();
      if (c == CHUNKS - 2) begin
        hold_asked++;
      end
      send_random_blocks(RANDOM_BEATS / CHUNKS);
    end

    wait_drained();
    repeat (LATENCY + 16) @(posedge clk_i);

    $display("covered %0d blocks in both directions under %0d key register writes,",
             beats_sent, cfg_writes);
    $display("with %0d cycles of input stall while the pipeline was backed up",
             input_stalls);
    if (error_count == 0) begin
      $display("xtea_block_cipher_test: done, clean");
    end else begin
      $display("xtea_block_cipher_test: done, errors");
    end
    $finish;
  end

endmodule
